### src/scmmx_pkg.sv
package scmmx_pkg;

  localparam int TRACKS      = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int POINTS_DEF  = 256;

  localparam int TRACK_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int PIDX_W  = 8;
  localparam int FPP_W   = 20;
  localparam int THR_W   = 16;
  localparam int CFG_W   = 20;
  localparam int CFG_IDX_W = 2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [TRACKS-1:0] samples_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_ENABLE   = 2'd0,
    CFG_FRAMES_PER_POINT = 2'd1,
    CFG_TRIGGER_HIGH     = 2'd2,
    CFG_TRIGGER_LOW      = 2'd3
  } cfg_idx_t;

  localparam logic             RST_TRIGGER_ENABLE   = 1'b1;
  localparam logic [FPP_W-1:0] RST_FRAMES_PER_POINT = 20'd94;
  localparam logic signed [THR_W-1:0] RST_TRIGGER_HIGH = 16'sd3;
  localparam logic signed [THR_W-1:0] RST_TRIGGER_LOW  = 16'sd0;

  // one finished window, all tracks
  typedef struct packed {
    logic [PIDX_W-1:0] point;
    samples_t          mins;
    samples_t          maxs;
  } window_t;

endpackage

### src/triggered_min_max_scope_capture_core.sv
// a closed window passes through the queue, the window register and the output register
// throughput: while out_ready is high, one frame per cycle if windows span 8 or more
//   frames; each closed window sends 8 results, one per cycle, via the output register
// a two-entry window queue between the min/max tracker and the serializer absorbs stalls
// reset (synchronous, rst_n low): registers to defaults, trackers cleared, sweep starts
//   at once, trigger detector high, queue and output empty
module triggered_min_max_scope_capture_core #(
  parameter int POINTS = scmmx_pkg::POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [scmmx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scmmx_pkg::CFG_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  scmmx_pkg::sample_t                in_sample_0,
  input  scmmx_pkg::sample_t                in_sample_1,
  input  scmmx_pkg::sample_t                in_sample_2,
  input  scmmx_pkg::sample_t                in_sample_3,
  input  scmmx_pkg::sample_t                in_sample_4,
  input  scmmx_pkg::sample_t                in_sample_5,
  input  scmmx_pkg::sample_t                in_sample_6,
  input  scmmx_pkg::sample_t                in_sample_7,
  input  logic [scmmx_pkg::TRACKS-1:0]      in_connected_mask,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [scmmx_pkg::TRACK_W-1:0]     out_track,
  output logic [scmmx_pkg::PIDX_W-1:0]      out_point_index,
  output scmmx_pkg::sample_t                out_window_min,
  output scmmx_pkg::sample_t                out_window_max,
  output logic                              out_last_of_point
);

  scmmx_pkg::samples_t samples;
  scmmx_pkg::window_t  q_wdata, q_rdata;
  logic                q_push, q_full, q_pop, q_valid;

  assign samples[0] = in_sample_0;
  assign samples[1] = in_sample_1;
  assign samples[2] = in_sample_2;
  assign samples[3] = in_sample_3;
  assign samples[4] = in_sample_4;
  assign samples[5] = in_sample_5;
  assign samples[6] = in_sample_6;
  assign samples[7] = in_sample_7;

  scmmx_front #(
    .POINTS(POINTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (scmmx_pkg::cfg_idx_t'(cfg_index)),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_samples (samples),
    .in_mask    (in_connected_mask),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  scmmx_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  scmmx_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_track         (out_track),
    .out_point_index   (out_point_index),
    .out_window_min    (out_window_min),
    .out_window_max    (out_window_max),
    .out_last_of_point (out_last_of_point)
  );

endmodule

### src/scmmx_front.sv
module scmmx_front #(
  parameter int POINTS = scmmx_pkg::POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  scmmx_pkg::cfg_idx_t                 cfg_index,
  input  logic [scmmx_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  scmmx_pkg::samples_t                 in_samples,
  input  logic [scmmx_pkg::TRACKS-1:0]        in_mask,
  input  logic                                q_full,
  output logic                                q_push,
  output scmmx_pkg::window_t                  q_wdata
);

  localparam int POS_W = $clog2(POINTS) + 1;
  localparam logic [POS_W-1:0] POS_DONE = POS_W'(POINTS);

  logic                                   trig_en_r;
  logic [scmmx_pkg::FPP_W-1:0]            fpp_r;
  logic signed [scmmx_pkg::THR_W-1:0]     thr_high_r;
  logic signed [scmmx_pkg::THR_W-1:0]     thr_low_r;

  scmmx_pkg::samples_t                    min_r, min_nxt, min_new;
  scmmx_pkg::samples_t                    max_r, max_nxt, max_new;
  logic [scmmx_pkg::FPP_W-1:0]            cnt_r, cnt_nxt, cnt_inc, win_len;
  logic [POS_W-1:0]                       pos_r, pos_nxt, eff_pos;
  logic                                   sh_r, sh_nxt;

  logic                                   accept, done, go, fire, found, running, win_end;
  scmmx_pkg::sample_t                     sel_sample;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign done     = (pos_r == POS_DONE);
  assign win_len  = (fpp_r == '0) ? scmmx_pkg::FPP_W'(1) : fpp_r;

  // first connected track feeds the trigger
  always_comb begin
    found      = 1'b0;
    sel_sample = '0;
    for (int i = 0; i < scmmx_pkg::TRACKS; i++) begin
      if (!found && in_mask[i]) begin
        found      = 1'b1;
        sel_sample = in_samples[i];
      end
    end
  end

  // schmitt detector, only advanced while waiting for a restart
  always_comb begin
    fire   = 1'b0;
    sh_nxt = sh_r;
    if (accept && done && trig_en_r && found) begin
      if (sh_r) begin
        if (sel_sample <= thr_low_r) sh_nxt = 1'b0;
      end else if (sel_sample >= thr_high_r) begin
        sh_nxt = 1'b1;
        fire   = 1'b1;
      end
    end
    go = done && (!trig_en_r || fire);
    if (accept && go) sh_nxt = 1'b1;
  end

  always_comb begin
    for (int i = 0; i < scmmx_pkg::TRACKS; i++) begin
      min_new[i] = ($signed(in_samples[i]) < $signed(min_r[i])) ? in_samples[i] : min_r[i];
      max_new[i] = ($signed(in_samples[i]) > $signed(max_r[i])) ? in_samples[i] : max_r[i];
    end
  end

  assign running = !done || go;
  assign eff_pos = go ? '0 : pos_r;
  assign cnt_inc = (go ? '0 : cnt_r) + scmmx_pkg::FPP_W'(1);
  assign win_end = accept && running && (cnt_inc >= win_len);

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (accept && running) begin
      if (win_end) begin
        for (int i = 0; i < scmmx_pkg::TRACKS; i++) begin
          min_nxt[i] = scmmx_pkg::SAMPLE_MAX;
          max_nxt[i] = scmmx_pkg::SAMPLE_MIN;
        end
        cnt_nxt = '0;
        pos_nxt = eff_pos + POS_W'(1);
      end else begin
        min_nxt = min_new;
        max_nxt = max_new;
        cnt_nxt = cnt_inc;
        pos_nxt = eff_pos;
      end
    end
  end

  assign q_push        = win_end;
  assign q_wdata.point = scmmx_pkg::PIDX_W'(eff_pos);
  assign q_wdata.mins  = min_new;
  assign q_wdata.maxs  = max_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_en_r  <= scmmx_pkg::RST_TRIGGER_ENABLE;
      fpp_r      <= scmmx_pkg::RST_FRAMES_PER_POINT;
      thr_high_r <= scmmx_pkg::RST_TRIGGER_HIGH;
      thr_low_r  <= scmmx_pkg::RST_TRIGGER_LOW;
      for (int i = 0; i < scmmx_pkg::TRACKS; i++) begin
        min_r[i] <= scmmx_pkg::SAMPLE_MAX;
        max_r[i] <= scmmx_pkg::SAMPLE_MIN;
      end
      cnt_r <= '0;
      pos_r <= '0;
      sh_r  <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          scmmx_pkg::CFG_TRIGGER_ENABLE:   trig_en_r  <= cfg_data[0];
          scmmx_pkg::CFG_FRAMES_PER_POINT: fpp_r      <= cfg_data[scmmx_pkg::FPP_W-1:0];
          scmmx_pkg::CFG_TRIGGER_HIGH:     thr_high_r <= cfg_data[scmmx_pkg::THR_W-1:0];
          scmmx_pkg::CFG_TRIGGER_LOW:      thr_low_r  <= cfg_data[scmmx_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      min_r <= min_nxt;
      max_r <= max_nxt;
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
      sh_r  <= sh_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n) pos_r <= POS_DONE)
    else $error("sweep position beyond end of sweep");

  // a finished sweep leaves the counter and trackers cleared for the restart frame; checked on track 0
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (cnt_r == '0) && (min_r[0] == scmmx_pkg::SAMPLE_MAX)
             && (max_r[0] == scmmx_pkg::SAMPLE_MIN))
    else $error("trackers not clear while waiting for restart");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("window pushed into a full queue");

endmodule

### src/scmmx_queue.sv
module scmmx_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  scmmx_pkg::window_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               rvalid,
  output scmmx_pkg::window_t rdata
);

  scmmx_pkg::window_t                 mem_r [scmmx_pkg::Q_DEPTH];
  logic [scmmx_pkg::Q_PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [scmmx_pkg::Q_CNT_W-1:0]      cnt_r;
  logic                               do_push, do_pop;

  assign full    = (cnt_r == scmmx_pkg::Q_CNT_W'(scmmx_pkg::Q_DEPTH));
  assign rvalid  = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + scmmx_pkg::Q_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + scmmx_pkg::Q_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + scmmx_pkg::Q_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - scmmx_pkg::Q_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> rvalid)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= scmmx_pkg::Q_CNT_W'(scmmx_pkg::Q_DEPTH))
    else $error("queue count out of range");

  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !pop) |=> rvalid)
    else $error("pushed entry not visible");

endmodule

### src/scmmx_back.sv
module scmmx_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  scmmx_pkg::window_t                 q_rdata,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [scmmx_pkg::TRACK_W-1:0]      out_track,
  output logic [scmmx_pkg::PIDX_W-1:0]       out_point_index,
  output scmmx_pkg::sample_t                 out_window_min,
  output scmmx_pkg::sample_t                 out_window_max,
  output logic                               out_last_of_point
);

  localparam logic [scmmx_pkg::TRACK_W-1:0] LAST_TRK = scmmx_pkg::TRACK_W'(scmmx_pkg::TRACKS - 1);

  scmmx_pkg::window_t                  win_r;
  logic                                busy_r;
  logic [scmmx_pkg::TRACK_W-1:0]       idx_r;

  logic                                out_valid_r;
  logic [scmmx_pkg::TRACK_W-1:0]       out_track_r;
  logic [scmmx_pkg::PIDX_W-1:0]        out_point_r;
  scmmx_pkg::sample_t                  out_min_r, out_max_r;
  logic                                out_last_r;

  logic                                out_free, emit, last;

  assign out_free = !out_valid_r || out_ready;
  assign emit     = busy_r && out_free;
  assign last     = (idx_r == LAST_TRK);
  // next window is loaded as the last track of the current one goes out
  assign q_pop    = q_valid && (!busy_r || (emit && last));

  always_ff @(posedge clk) begin
    if (q_pop) win_r <= q_rdata;
    if (emit) begin
      out_track_r <= idx_r;
      out_point_r <= win_r.point;
      out_min_r   <= win_r.mins[idx_r];
      out_max_r   <= win_r.maxs[idx_r];
      out_last_r  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (emit) begin
        if (last) busy_r <= 1'b0;
        idx_r <= idx_r + scmmx_pkg::TRACK_W'(1);
      end
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_track         = out_track_r;
  assign out_point_index   = out_point_r;
  assign out_window_min    = out_min_r;
  assign out_window_max    = out_max_r;
  assign out_last_of_point = out_last_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n) idx_r <= LAST_TRK)
    else $error("track index out of range");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("stalled result dropped");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> (out_last_r && out_track_r == LAST_TRK))
    else $error("last result of a point not flagged");

endmodule
